@@ hdl/tilt_led_moving_average_pwm_macros.svh @@
// Assertion macros shared by the checker files of the tilt LED filter.
// Depends on i_clk and i_rst_n being visible where the macros are used.
`ifndef TILT_LED_MOVING_AVERAGE_PWM_MACROS_SVH
`define TILT_LED_MOVING_AVERAGE_PWM_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define TLMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define TLMA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/tlma_pkg.sv @@
// Package for the tilt LED moving-average block: sizes, register indexes,
// reset values and the LED position table. No dependencies.
`default_nettype none

package tlma_pkg;

    // Default sizes of the history window and of one sample
    localparam int WINDOW_LENGTH_DEF = 128;
    localparam int SAMPLE_WIDTH_DEF  = 13;

    // Average is the running sum shifted right by this amount
    localparam int AVG_SHIFT = 7;

    // Register and field widths
    localparam int TILT_W     = 9;
    localparam int PERIOD_W   = 5;
    localparam int LED_W      = 8;
    localparam int LEVEL_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Bit positions of the LED select and the duty level in the adjusted average
    localparam int LED_SEL_HI = 8;
    localparam int LED_SEL_LO = 6;
    localparam int LEVEL_HI   = 5;
    localparam int LEVEL_LO   = 1;
    localparam int ADJ_MIN_W  = LED_SEL_HI + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_OFFSET   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DITHER_PERIOD = 1'd1;

    // Register reset values
    localparam logic signed [TILT_W-1:0] TILT_OFFSET_RST   = -9'sd32;
    localparam logic [PERIOD_W-1:0]      DITHER_PERIOD_RST = 5'd16;

    typedef logic [LED_W-1:0] t_led;

    // One-hot LED position for a 3-bit tilt bucket
    function automatic t_led led_map(input logic [2:0] sel);
        t_led pat;
        case (sel)
            3'd0:    pat = 8'h08;
            3'd1:    pat = 8'h04;
            3'd2:    pat = 8'h02;
            3'd3:    pat = 8'h01;
            3'd4:    pat = 8'h80;
            3'd5:    pat = 8'h40;
            3'd6:    pat = 8'h20;
            3'd7:    pat = 8'h10;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tlma_in_if.sv @@
// Input channel of the tilt LED block: mode and sample words with valid/ready.
// Depends on tlma_pkg for the default sample width.
`default_nettype none

interface tlma_in_if #(
    parameter int SAMPLE_WIDTH = tlma_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

`default_nettype wire

@@ hdl/tlma_out_if.sv @@
// Output channel of the tilt LED block: LED drive, average and duty level.
// Depends on tlma_pkg for the field widths.
`default_nettype none

interface tlma_out_if #(
    parameter int SAMPLE_WIDTH = tlma_pkg::SAMPLE_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic [tlma_pkg::LED_W-1:0]        led_drive;
    logic signed [SAMPLE_WIDTH-1:0]    filtered;
    logic [tlma_pkg::LEVEL_W-1:0]      dither_level;

    modport source (output valid, output led_drive, output filtered, output dither_level,
                    input ready);
    modport sink   (input valid, input led_drive, input filtered, input dither_level,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/tilt_led_moving_average_pwm.sv @@
// Tilt LED block: boxcar average over the sample history, LED position and PWM dither.
// Depends on tlma_pkg, tlma_in_if and tlma_out_if.
//
// The block takes one word per clock, sample or tick, with no bubbles while the sink keeps
// taking results. A word is first held in stage one, then its result loads the output
// register. At the accept of a sample the history RAM (single port, read-first) returns
// the oldest sample and stores the new one; when stage one drains, the running sum, LED
// position and duty level (on a sample) or the PWM counter (on a tick) update.
// The output register decouples the sides, so words keep flowing while a result waits
// unless the one pipeline slot is also full. There is no clearing pass after reset:
// a wrap flag marks the history as unfilled until the pointer first passes the last entry,
// and until then the oldest sample reads as zero.
`default_nettype none

module tilt_led_moving_average_pwm #(
    parameter int WINDOW_LENGTH = tlma_pkg::WINDOW_LENGTH_DEF,
    parameter int SAMPLE_WIDTH  = tlma_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tlma_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tlma_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tlma_in_if.sink                              i_in,
    tlma_out_if.source                           o_out
);
    import tlma_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_LENGTH);
    localparam int SUM_W = SAMPLE_WIDTH + PTR_W;
    localparam int ADJ_W = (SUM_W + 1 > ADJ_MIN_W) ? SUM_W + 1 : ADJ_MIN_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LENGTH - 1);

    // History RAM
    logic signed [SAMPLE_WIDTH-1:0] mem_hist [WINDOW_LENGTH];
    logic signed [SAMPLE_WIDTH-1:0] r_rd_data;

    // Control and state registers
    logic [PTR_W-1:0]            r_ptr;
    logic                        r_wrapped;
    logic                        r_s1_valid;
    logic signed [SUM_W-1:0]     r_sum;
    t_led                        r_led;
    logic [LEVEL_W-1:0]          r_duty;
    logic [PERIOD_W-1:0]         r_pwm;
    logic signed [TILT_W-1:0]    r_tilt_offset;
    logic [PERIOD_W-1:0]         r_dither_period;
    logic                        r_out_valid;

    // Stage-one payload
    logic                           r_s1_mode;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_sample;
    logic                           r_s1_wrapped;

    // Output payload
    t_led                           r_out_led;
    logic signed [SAMPLE_WIDTH-1:0] r_out_filtered;
    logic [LEVEL_W-1:0]             r_out_level;

    logic                           in_acc;
    logic                           s1_adv;
    logic                           s1_fire;
    logic signed [SAMPLE_WIDTH-1:0] old_sample;
    logic signed [SUM_W-1:0]        n_sum;
    logic signed [SUM_W-1:0]        cur_sum;
    logic signed [SUM_W-1:0]        avg;
    logic signed [ADJ_W-1:0]        adj;
    t_led                           n_led;
    logic [LEVEL_W-1:0]             n_duty;
    t_led                           tick_drive;
    logic [PERIOD_W-1:0]            n_pwm;
    logic [PTR_W-1:0]               n_ptr;

    // Handshake: stage one drains when the output register is free or being taken
    assign s1_adv      = !r_out_valid || o_out.ready;
    assign s1_fire     = r_s1_valid && s1_adv;
    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign in_acc      = i_in.valid && i_in.ready;

    // Advance the history pointer, wrapping at the last entry
    assign n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;

    // Swap the oldest sample out of the RAM and the new one in
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_in.mode) begin
            r_rd_data      <= mem_hist[r_ptr];
            mem_hist[r_ptr] <= i_in.sample;
        end
    end

    // Update the running sum and derive the LED position and duty level
    always_comb begin
        old_sample = r_s1_wrapped ? r_rd_data : '0;
        n_sum      = r_sum + SUM_W'(r_s1_sample) - SUM_W'(old_sample);
        cur_sum    = r_s1_mode ? r_sum : n_sum;
        avg        = cur_sum >>> AVG_SHIFT;
        adj        = ADJ_W'(avg) + ADJ_W'(r_tilt_offset);
        n_led      = led_map(adj[LED_SEL_HI:LED_SEL_LO]);
        n_duty     = adj[LEVEL_HI:LEVEL_LO];
    end

    // Dither the LED pattern and advance the PWM counter on a tick
    always_comb begin
        tick_drive = (PERIOD_W'(r_pwm) < PERIOD_W'(r_duty)) ? (r_led >> 1) : r_led;
        n_pwm      = (r_pwm > r_dither_period) ? '0 : r_pwm + 1'b1;
    end

    // Hold control state, configuration and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr           <= '0;
            r_wrapped       <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_sum           <= '0;
            r_led           <= '0;
            r_duty          <= '0;
            r_pwm           <= '0;
            r_tilt_offset   <= TILT_OFFSET_RST;
            r_dither_period <= DITHER_PERIOD_RST;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TILT_OFFSET:   r_tilt_offset   <= i_cfg_data[TILT_W-1:0];
                    CFG_DITHER_PERIOD: r_dither_period <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc && !i_in.mode) begin
                r_ptr <= n_ptr;
                if (r_ptr == PTR_LAST) begin
                    r_wrapped <= 1'b1;
                end
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire) begin
                if (r_s1_mode) begin
                    r_pwm <= n_pwm;
                end else begin
                    r_sum  <= n_sum;
                    r_led  <= n_led;
                    r_duty <= n_duty;
                end
            end

            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the word into stage one
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode    <= i_in.mode;
            r_s1_sample  <= i_in.sample;
            r_s1_wrapped <= r_wrapped;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_led      <= r_s1_mode ? tick_drive : n_led;
            r_out_filtered <= avg[SAMPLE_WIDTH-1:0];
            r_out_level    <= r_s1_mode ? r_duty : n_duty;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.led_drive    = r_out_led;
    assign o_out.filtered     = r_out_filtered;
    assign o_out.dither_level = r_out_level;

endmodule

`default_nettype wire

@@ hdl/tlma_checker.sv @@
// Port-level checks for the tilt LED block, bound to its top level.
// Depends on tlma_pkg and tilt_led_moving_average_pwm_macros.svh.
`default_nettype none

`include "tilt_led_moving_average_pwm_macros.svh"

module tlma_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [tlma_pkg::LED_W-1:0] i_led_drive
);
    // Nothing shows on the output right after reset
    `TLMA_ASSERT_RST(a_rst_idle, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // A stalled result word stays offered
    `TLMA_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped")

    // The LED drive is a single lit position or dark
    `TLMA_ASSERT(a_led_onehot, i_out_valid |-> $onehot0(i_led_drive), "LED drive not one-hot")

    // An accepted word reaches the output when the sink is ready while the word sits in stage one
    `TLMA_ASSERT(a_latency, (i_in_valid && i_in_ready) ##1 i_out_ready |=> i_out_valid,
        "result late")

endmodule

bind tilt_led_moving_average_pwm tlma_checker u_tlma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_led_drive (o_out.led_drive)
);

`default_nettype wire
